/* sv/hist_eq_pkg.sv */
// ----------------------------------------------------------------------------
// hist_eq_pkg
// Shared constants, mode codes and controller/datapath interface types for
// the grey-level histogram equalizer.
// ----------------------------------------------------------------------------
package hist_eq_pkg;

  // grey levels and index width
  localparam int unsigned LEVELS  = 256;
  localparam int unsigned LVL_W   = $clog2(LEVELS);

  // histogram bin width and saturation value
  localparam int unsigned BIN_W   = 21;
  localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

  // pixel total register
  localparam int unsigned TOTAL_W = 21;

  // cumulative count holds the sum of all bins
  localparam int unsigned CUM_W   = BIN_W + LVL_W;

  // mapped value and scale factor
  localparam int unsigned QUO_W   = 8;
  localparam int unsigned STEP_W  = $clog2(QUO_W);
  localparam logic [QUO_W-1:0] MAP_TOP = {QUO_W{1'b1}};

  // scaled numerator cum * 255
  localparam int unsigned NUM_W   = CUM_W + QUO_W;

  // item modes
  typedef enum logic [1:0] {
    MODE_COUNT = 2'd0,
    MODE_BUILD = 2'd1,
    MODE_MAP   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;     // item taken this cycle, latch pixel and read stores
    logic clear;      // drop all histogram bins
    logic bld_start;  // reset the walk and latch the divisor
    logic rd_lvl;     // histogram read address from the walk counter
    logic cnt_wr;     // write back the incremented bin
    logic acc;        // add the bin to the running sum
    logic scale;      // form cum * 255 and check for clamp
    logic div_step;   // one restoring division step
    logic map_wr;     // write the map entry and advance the level
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic lvl_last;   // walk is on the top level
    logic div_last;   // last quotient bit in this step
  } status_t;

endpackage

/* sv/hist_eq_ctrl.sv */
// ----------------------------------------------------------------------------
// hist_eq_ctrl
// Controller for the histogram equalizer: takes items, sequences the count
// read-modify-write, the map lookup and the build walk over all levels.
// ----------------------------------------------------------------------------
module hist_eq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [1:0]            mode_i,
  input  hist_eq_pkg::status_t  status_i,
  output hist_eq_pkg::cmd_t     cmd_o,
  output logic                  busy_o,
  output logic                  result_valid_o
);
  import hist_eq_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_CNT_WR    = 8'b0000_0010,
    ST_MAP_OUT   = 8'b0000_0100,
    ST_BLD_RD    = 8'b0000_1000,
    ST_BLD_ACC   = 8'b0001_0000,
    ST_BLD_SCALE = 8'b0010_0000,
    ST_BLD_DIV   = 8'b0100_0000,
    ST_BLD_WR    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;
  mode_e  mode;

  assign mode   = mode_e'(mode_i);
  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i & ~busy_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode)
            MODE_COUNT: state_d = ST_CNT_WR;
            MODE_BUILD: state_d = ST_BLD_RD;
            MODE_MAP:   state_d = ST_MAP_OUT;
            MODE_CLEAR: state_d = ST_IDLE;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_CNT_WR:    state_d = ST_IDLE;
      ST_MAP_OUT:   state_d = ST_IDLE;
      ST_BLD_RD:    state_d = ST_BLD_ACC;
      ST_BLD_ACC:   state_d = ST_BLD_SCALE;
      ST_BLD_SCALE: state_d = ST_BLD_DIV;
      ST_BLD_DIV:   state_d = status_i.div_last ? ST_BLD_WR : ST_BLD_DIV;
      ST_BLD_WR:    state_d = status_i.lvl_last ? ST_IDLE : ST_BLD_RD;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.accept    = accept;
    cmd_o.clear     = accept && (mode == MODE_CLEAR);
    cmd_o.bld_start = accept && (mode == MODE_BUILD);
    cmd_o.rd_lvl    = (state_q == ST_BLD_RD);
    cmd_o.cnt_wr    = (state_q == ST_CNT_WR);
    cmd_o.acc       = (state_q == ST_BLD_ACC);
    cmd_o.scale     = (state_q == ST_BLD_SCALE);
    cmd_o.div_step  = (state_q == ST_BLD_DIV);
    cmd_o.map_wr    = (state_q == ST_BLD_WR);
  end

  // result beat strobe
  assign result_valid_o = (state_q == ST_MAP_OUT);

`ifndef SYNTHESIS
  // a result beat comes in the cycle after a map item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept && (mode == MODE_MAP)))
    else $error("result beat without a map item");

  // every item except clear keeps the unit busy for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode != MODE_CLEAR)) |=> busy_o)
    else $error("item accepted but unit not busy");

  // the walk ends right after the top level is written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_BLD_WR) && status_i.lvl_last) |=> !busy_o)
    else $error("build walk did not end after the top level");
`endif

endmodule

/* sv/hist_eq_datapath.sv */
// ----------------------------------------------------------------------------
// hist_eq_datapath
// Histogram and map stores, pixel total register, running sum and the
// restoring divider that scales the cumulative count into a grey level.
// ----------------------------------------------------------------------------
module hist_eq_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            pixel_i,
  input  logic                  cfg_we_i,
  input  logic [20:0]           cfg_data_i,
  input  hist_eq_pkg::cmd_t     cmd_i,
  output hist_eq_pkg::status_t  status_o,
  output logic [7:0]            mapped_pixel_o
);
  import hist_eq_pkg::*;

  // stores
  logic [BIN_W-1:0]  hist_mem [LEVELS];
  logic [QUO_W-1:0]  map_mem  [LEVELS];
  logic [LEVELS-1:0] vld_q;

  logic [TOTAL_W-1:0] total_q;
  logic [LVL_W-1:0]   pix_q;
  logic [LVL_W-1:0]   lvl_q;
  logic [BIN_W-1:0]   hist_rd_q;
  logic               vld_rd_q;
  logic [QUO_W-1:0]   map_rd_q;
  logic [CUM_W-1:0]   cum_q;
  logic [TOTAL_W-1:0] div_q;
  logic [CUM_W-1:0]   rem_q;
  logic [QUO_W-1:0]   quo_q;
  logic               sat_q;
  logic [STEP_W-1:0]  step_q;

  logic [LVL_W-1:0]   hist_raddr;
  logic [BIN_W-1:0]   bin;
  logic [BIN_W-1:0]   bin_inc;
  logic [NUM_W-1:0]   num;
  logic [NUM_W-1:0]   div_top;
  logic [CUM_W-1:0]   dsh;
  logic               ge;

  // pixel total register, reset to one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_W'(1);
    end else if (cfg_we_i) begin
      total_q <= cfg_data_i;
    end
  end

  // histogram read, bins not yet counted read as zero
  assign hist_raddr = cmd_i.rd_lvl ? lvl_q : pixel_i;

  always_ff @(posedge clk_i) begin
    hist_rd_q <= hist_mem[hist_raddr];
    if (cmd_i.cnt_wr) begin
      hist_mem[pix_q] <= bin_inc;
    end
  end

  assign bin     = vld_rd_q ? hist_rd_q : '0;
  assign bin_inc = (bin == BIN_MAX) ? bin : bin + BIN_W'(1);

  // per-bin valid flags, clear drops them all at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      vld_rd_q <= vld_q[hist_raddr];
      if (cmd_i.clear) begin
        vld_q <= '0;
      end else if (cmd_i.cnt_wr) begin
        vld_q[pix_q] <= 1'b1;
      end
    end
  end

  // map table, read on the map item, written by the walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      map_rd_q <= map_mem[pixel_i];
    end
    if (cmd_i.map_wr) begin
      map_mem[lvl_q] <= sat_q ? MAP_TOP : quo_q;
    end
  end

  assign mapped_pixel_o = map_rd_q;

  // pixel latch for the count write-back
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_q <= pixel_i;
    end
  end

  // scaled numerator cum * 255 and clamp threshold div * 256
  assign num     = {cum_q, QUO_W'(0)} - NUM_W'(cum_q);
  assign div_top = NUM_W'({div_q, QUO_W'(0)});

  // divisor shifted to the current quotient bit
  assign dsh = CUM_W'(div_q) << step_q;
  assign ge  = (rem_q >= dsh);

  // build walk: running sum, scale, restoring division
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= '0;
    end else if (cmd_i.bld_start) begin
      lvl_q <= '0;
    end else if (cmd_i.map_wr) begin
      lvl_q <= lvl_q + LVL_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bld_start) begin
      cum_q <= '0;
      div_q <= (total_q == '0) ? TOTAL_W'(1) : total_q;
    end
    if (cmd_i.acc) begin
      cum_q <= cum_q + CUM_W'(bin);
    end
    if (cmd_i.scale) begin
      sat_q  <= (num >= div_top);
      rem_q  <= num[CUM_W-1:0];
      quo_q  <= '0;
      step_q <= STEP_W'(QUO_W - 1);
    end
    if (cmd_i.div_step) begin
      quo_q[step_q] <= ge;
      if (ge) begin
        rem_q <= rem_q - dsh;
      end
      step_q <= step_q - STEP_W'(1);
    end
  end

  // status to the controller
  assign status_o.lvl_last = (lvl_q == LVL_W'(LEVELS - 1));
  assign status_o.div_last = (step_q == '0);

endmodule

/* sv/histogram_equalizer_unit.sv */
// ----------------------------------------------------------------------------
// histogram_equalizer_unit
// 8-bit grey-level histogram equalization: counts pixels into a histogram,
// builds a map table from the cumulative count and maps pixels through it.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                 | dir | handshake
//  ---------+-----------------------------------------+-----+----------------
//  item     | start, busy, mode_i, pixel_i            | in  | start & !busy
//  result   | result_valid_o, mapped_pixel_o          | out | one-cycle strobe
//  config   | cfg_valid_i, cfg_ready_o, cfg_data_i    | in  | valid & ready
//
//  clear acts on accept; count reads the bin, then writes it back; map gives
//  the result beat from the registered table read; build accepts, then per level
//  reads, adds, scales, runs eight one-bit-a-cycle divider steps and writes.
//  reset: all bins read as zero right after reset, pixel total resets to 1;
//  the map table holds nothing until a build has run.
//  result beats cannot be stalled; busy stays high while an item is at work.
//
module histogram_equalizer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  pixel_i,
  output logic        result_valid_o,
  output logic [7:0]  mapped_pixel_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [20:0] cfg_data_i
);
  import hist_eq_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    cfg_we;

  // register writes taken only while idle
  assign cfg_ready_o = ~busy;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  hist_eq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .mode_i         (mode_i),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy_o         (busy),
    .result_valid_o (result_valid_o)
  );

  hist_eq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pixel_i        (pixel_i),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .mapped_pixel_o (mapped_pixel_o)
  );

endmodule
